// ===== src/vrl_pkg.sv =====
// Shared constants, types and widths of the VSWR to return loss converter.
`timescale 1ns / 1ps
package vrl_pkg;
   localparam int INPUT_FRAC_BITS = 16;
   localparam int DB_FRAC_BITS    = 8;

   localparam int VSWR_W    = 24;
   localparam int ARG_W     = VSWR_W + 1;
   localparam int GAMMA_W   = 16;
   localparam int QUOT_W    = GAMMA_W + 1;
   localparam int DIVD_W    = VSWR_W + GAMMA_W + 1;
   localparam int RL_W      = 15;
   localparam int IL_W      = 12;

   localparam int LOG_FRAC  = 28;
   localparam int LOG_INT_W = 5;
   localparam int LOG_W     = LOG_INT_W + LOG_FRAC;
   localparam int MANT_W    = 31;
   localparam int MANT_TOP  = MANT_W - 1;

   localparam int K_W       = 26;
   localparam logic [K_W-1:0] K10LOG2 = K_W'(50504453);
   localparam int DIFF_W    = LOG_W + 3;
   localparam int MAG_W     = DIFF_W - 1;
   localparam int SPLIT     = 18;
   localparam int PL_W      = SPLIT + K_W;
   localparam int PH_W      = MAG_W - SPLIT + K_W;
   localparam int SUM_W     = MAG_W + K_W;
   localparam int PROD_FRAC = LOG_FRAC + 24;
   localparam int DB_SHIFT  = PROD_FRAC - DB_FRAC_BITS;
   localparam int DBR_W     = SUM_W - DB_SHIFT;

   localparam int LOG_LAT    = LOG_FRAC + 1;
   localparam int DB_LAT     = 2;
   localparam int DIV_LAT    = QUOT_W;
   localparam int PIPE_DEPTH = LOG_LAT + DB_LAT + 2;
   localparam int STAT_DLY   = PIPE_DEPTH - 2;
   localparam int GAMMA_DLY  = PIPE_DEPTH - 2 - DIV_LAT;

   localparam logic [RL_W-1:0] RL_MAX = {RL_W{1'b1}};
   localparam logic [DBR_W-1:0] IL_MIN_MAG = DBR_W'(1) << (IL_W - 1);

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_BELOW_ONE = 2'd1,
      STATUS_UNITY     = 2'd2
   } status_type;

   typedef struct packed {
      logic             neg;
      logic [DBR_W-1:0] mag;
   } db_type;
endpackage

// ===== src/vrl_if.sv =====
// Valid/ready channel interfaces for the request and response words.
`timescale 1ns / 1ps
interface vrl_req_if import vrl_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [VSWR_W-1:0] vswr_ratio;
   modport source (output valid, output vswr_ratio, input ready);
   modport sink (input valid, input vswr_ratio, output ready);
endinterface

interface vrl_rsp_if import vrl_pkg::*; ();
   logic                   valid;
   logic                   ready;
   status_type             status;
   logic [GAMMA_W-1:0]     reflection_coeff;
   logic [RL_W-1:0]        return_loss_db;
   logic [RL_W-1:0]        mismatch_loss_db;
   logic signed [IL_W-1:0] insertion_loss_db;
   modport source (output valid, output status, output reflection_coeff,
                   output return_loss_db, output mismatch_loss_db,
                   output insertion_loss_db, input ready);
   modport sink (input valid, input status, input reflection_coeff,
                 input return_loss_db, input mismatch_loss_db,
                 input insertion_loss_db, output ready);
endinterface

// ===== src/vrl_divider.sv =====
// Pipelined restoring divider for the rounded reflection coefficient.
`timescale 1ns / 1ps
module vrl_divider import vrl_pkg::*; (
   input  logic               clock,
   input  logic               advance,
   input  logic [ARG_W-1:0]   a_val,
   input  logic [ARG_W-1:0]   b_val,
   output logic [GAMMA_W-1:0] gamma
);
   logic [ARG_W-1:0]  rem_ff  [DIV_LAT];
   logic [QUOT_W-1:0] low_ff  [DIV_LAT];
   logic [QUOT_W-1:0] quot_ff [DIV_LAT];
   logic [ARG_W-1:0]  div_ff  [DIV_LAT];
   logic [ARG_W-1:0]  rem_in  [DIV_LAT];
   logic [QUOT_W-1:0] low_in  [DIV_LAT];
   logic [QUOT_W-1:0] quot_in [DIV_LAT];
   logic [DIVD_W-1:0] dividend;

   assign dividend = (DIVD_W'(a_val) << GAMMA_W) + DIVD_W'(b_val >> 1);

   for (genvar s = 0; s < DIV_LAT; s++) begin : g_step
      logic [ARG_W-1:0]  rem_prev;
      logic [QUOT_W-1:0] low_prev;
      logic [QUOT_W-1:0] quot_prev;
      logic [ARG_W-1:0]  div_prev;
      logic [ARG_W:0]    trial;
      if (s == 0) begin : g_first
         assign rem_prev  = ARG_W'(dividend[DIVD_W-1:QUOT_W]);
         assign low_prev  = dividend[QUOT_W-1:0];
         assign quot_prev = '0;
         assign div_prev  = b_val;
      end else begin : g_next
         assign rem_prev  = rem_ff[s-1];
         assign low_prev  = low_ff[s-1];
         assign quot_prev = quot_ff[s-1];
         assign div_prev  = div_ff[s-1];
      end
      always_comb begin
         trial = {rem_prev, low_prev[QUOT_W-1]};
         low_in[s] = {low_prev[QUOT_W-2:0], 1'b0};
         if (trial >= {1'b0, div_prev}) begin
            rem_in[s]  = ARG_W'(trial - {1'b0, div_prev});
            quot_in[s] = {quot_prev[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in[s]  = trial[ARG_W-1:0];
            quot_in[s] = {quot_prev[QUOT_W-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            rem_ff[s]  <= rem_in[s];
            low_ff[s]  <= low_in[s];
            quot_ff[s] <= quot_in[s];
            div_ff[s]  <= div_prev;
         end
      end
   end

   assign gamma = quot_ff[DIV_LAT-1][QUOT_W-1] ? {GAMMA_W{1'b1}}
                                               : quot_ff[DIV_LAT-1][GAMMA_W-1:0];
endmodule

// ===== src/vrl_log2.sv =====
// Pipelined base-two logarithm by repeated squaring, one fraction bit per stage.
`timescale 1ns / 1ps
module vrl_log2 import vrl_pkg::*; (
   input  logic             clock,
   input  logic             advance,
   input  logic [ARG_W-1:0] x_val,
   output logic [LOG_W-1:0] log_val
);
   logic [LOG_INT_W-1:0] int_ff  [LOG_LAT];
   logic [MANT_W-1:0]    mant_ff [LOG_LAT];
   logic [LOG_FRAC-1:0]  frac_ff [LOG_LAT];
   logic [LOG_INT_W-1:0] top_idx;
   logic [MANT_W-1:0]    x_wide;

   always_comb begin
      top_idx = '0;
      for (int i = 1; i < ARG_W; i++) begin
         if (x_val[i]) begin
            top_idx = LOG_INT_W'(i);
         end
      end
   end

   assign x_wide = MANT_W'(x_val);

   always_ff @(posedge clock) begin
      if (advance) begin
         int_ff[0]  <= top_idx;
         mant_ff[0] <= x_wide << (LOG_INT_W'(MANT_TOP) - top_idx);
         frac_ff[0] <= '0;
      end
   end

   for (genvar s = 1; s < LOG_LAT; s++) begin : g_sq
      logic [2*MANT_W-1:0] square;
      logic [MANT_W:0]     scaled;
      logic [MANT_W-1:0]   mant_in;
      always_comb begin
         square  = (2*MANT_W)'(mant_ff[s-1]) * (2*MANT_W)'(mant_ff[s-1]);
         scaled  = square[2*MANT_W-1:MANT_TOP];
         mant_in = scaled[MANT_W] ? scaled[MANT_W:1] : scaled[MANT_W-1:0];
      end
      always_ff @(posedge clock) begin
         if (advance) begin
            int_ff[s]  <= int_ff[s-1];
            mant_ff[s] <= mant_in;
            frac_ff[s] <= {frac_ff[s-1][LOG_FRAC-2:0], scaled[MANT_W]};
         end
      end
   end

   assign log_val = {int_ff[LOG_LAT-1], frac_ff[LOG_LAT-1]};
endmodule

// ===== src/vrl_to_db.sv =====
// Scales a log2 difference to decibels with a split multiply and rounding.
`timescale 1ns / 1ps
module vrl_to_db import vrl_pkg::*; (
   input  logic                     clock,
   input  logic                     advance,
   input  logic signed [DIFF_W-1:0] diff,
   output db_type                   db
);
   logic             neg_ff;
   logic [MAG_W-1:0] mag_ff;
   logic             neg2_ff;
   logic [PL_W-1:0]  pl_ff;
   logic [PH_W-1:0]  ph_ff;
   logic [MAG_W-1:0] mag_in;
   logic [PL_W-1:0]  pl_in;
   logic [PH_W-1:0]  ph_in;
   logic [SUM_W-1:0] sum;

   assign mag_in = diff[DIFF_W-1] ? MAG_W'(-diff) : MAG_W'(diff);
   assign pl_in  = PL_W'(mag_ff[SPLIT-1:0]) * PL_W'(K10LOG2);
   assign ph_in  = PH_W'(mag_ff[MAG_W-1:SPLIT]) * PH_W'(K10LOG2);

   always_ff @(posedge clock) begin
      if (advance) begin
         neg_ff  <= diff[DIFF_W-1];
         mag_ff  <= mag_in;
         neg2_ff <= neg_ff;
         pl_ff   <= pl_in;
         ph_ff   <= ph_in;
      end
   end

   assign sum = (SUM_W'(ph_ff) << SPLIT) + SUM_W'(pl_ff) + (SUM_W'(1) << (DB_SHIFT - 1));
   assign db.neg = neg2_ff;
   assign db.mag = sum[SUM_W-1:DB_SHIFT];
endmodule

// ===== src/vswr_to_reflection_and_losses.sv =====
// Top level of the VSWR to reflection coefficient and loss converter.
// The 28 squaring stages of the log2 units set the pipeline depth.
// Throughput: one word per cycle unless the response stalls.
// A stalled response freezes the whole pipeline, so nothing is lost or repeated.
// Reset is synchronous and active high; it clears only the valid bits.
`timescale 1ns / 1ps
module vswr_to_reflection_and_losses import vrl_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   vrl_req_if.sink       req,
   vrl_rsp_if.source     rsp
);
   localparam logic [ARG_W-1:0] ONE = ARG_W'(1) << INPUT_FRAC_BITS;
   localparam logic signed [DIFF_W-1:0] LOG_ONE = DIFF_W'(1) << LOG_FRAC;
   localparam logic signed [DIFF_W-1:0] ML_OFS = DIFF_W'(2 + INPUT_FRAC_BITS) << LOG_FRAC;

   logic                   advance;
   logic                   vld_ff  [PIPE_DEPTH];
   logic [VSWR_W-1:0]      v_ff;
   status_type             stat_ff [STAT_DLY];
   logic [GAMMA_W-1:0]     gam_ff  [GAMMA_DLY];
   logic [ARG_W-1:0]       v_ext, a_val, b_val;
   status_type             stat_in;
   logic [GAMMA_W-1:0]     gamma;
   logic [LOG_W-1:0]       lv, la, lb;
   logic signed [DIFF_W-1:0] rl_diff, ml_diff, il_diff;
   db_type                 rl_db, ml_db, il_db;
   status_type             status_ff;
   logic [GAMMA_W-1:0]     coeff_ff;
   logic [RL_W-1:0]        rl_ff, ml_ff;
   logic signed [IL_W-1:0] il_ff;
   logic [RL_W-1:0]        rl_in, ml_in;
   logic signed [IL_W-1:0] il_in;
   logic                   ok;

   assign advance   = !vld_ff[PIPE_DEPTH-1] || rsp.ready;
   assign req.ready = advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < PIPE_DEPTH; i++) begin
            vld_ff[i] <= 1'b0;
         end
      end else if (advance) begin
         vld_ff[0] <= req.valid;
         for (int i = 1; i < PIPE_DEPTH; i++) begin
            vld_ff[i] <= vld_ff[i-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         v_ff <= req.vswr_ratio;
      end
   end

   assign v_ext = ARG_W'(v_ff);
   assign a_val = v_ext - ONE;
   assign b_val = v_ext + ONE;

   always_comb begin
      if (v_ext < ONE) begin
         stat_in = STATUS_BELOW_ONE;
      end else if (v_ext == ONE) begin
         stat_in = STATUS_UNITY;
      end else begin
         stat_in = STATUS_OK;
      end
   end

   vrl_divider u_div (.clock, .advance, .a_val, .b_val, .gamma);
   vrl_log2 u_log_v (.clock, .advance, .x_val(v_ext), .log_val(lv));
   vrl_log2 u_log_a (.clock, .advance, .x_val(a_val), .log_val(la));
   vrl_log2 u_log_b (.clock, .advance, .x_val(b_val), .log_val(lb));

   always_ff @(posedge clock) begin
      if (advance) begin
         stat_ff[0] <= stat_in;
         for (int i = 1; i < STAT_DLY; i++) begin
            stat_ff[i] <= stat_ff[i-1];
         end
         gam_ff[0] <= gamma;
         for (int i = 1; i < GAMMA_DLY; i++) begin
            gam_ff[i] <= gam_ff[i-1];
         end
      end
   end

   assign rl_diff = (DIFF_W'(lb) - DIFF_W'(la)) <<< 1;
   assign ml_diff = (DIFF_W'(lb) <<< 1) - DIFF_W'(lv) - ML_OFS;
   assign il_diff = (DIFF_W'(lb) - DIFF_W'(lv) - LOG_ONE) <<< 1;

   vrl_to_db u_db_rl (.clock, .advance, .diff(rl_diff), .db(rl_db));
   vrl_to_db u_db_ml (.clock, .advance, .diff(ml_diff), .db(ml_db));
   vrl_to_db u_db_il (.clock, .advance, .diff(il_diff), .db(il_db));

   assign ok = (stat_ff[STAT_DLY-1] == STATUS_OK);

   always_comb begin
      if (!ok || rl_db.neg) begin
         rl_in = '0;
      end else if (rl_db.mag > DBR_W'(RL_MAX)) begin
         rl_in = RL_MAX;
      end else begin
         rl_in = rl_db.mag[RL_W-1:0];
      end
      if (!ok || ml_db.neg) begin
         ml_in = '0;
      end else if (ml_db.mag > DBR_W'(RL_MAX)) begin
         ml_in = RL_MAX;
      end else begin
         ml_in = ml_db.mag[RL_W-1:0];
      end
      if (!ok || !il_db.neg) begin
         il_in = '0;
      end else if (il_db.mag > IL_MIN_MAG) begin
         il_in = IL_W'(-IL_MIN_MAG);
      end else begin
         il_in = IL_W'(-il_db.mag);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         status_ff <= stat_ff[STAT_DLY-1];
         coeff_ff  <= ok ? gam_ff[GAMMA_DLY-1] : '0;
         rl_ff     <= rl_in;
         ml_ff     <= ml_in;
         il_ff     <= il_in;
      end
   end

   assign rsp.valid             = vld_ff[PIPE_DEPTH-1];
   assign rsp.status            = status_ff;
   assign rsp.reflection_coeff  = coeff_ff;
   assign rsp.return_loss_db    = rl_ff;
   assign rsp.mismatch_loss_db  = ml_ff;
   assign rsp.insertion_loss_db = il_ff;
endmodule

// ===== src/vrl_checker.sv =====
// Port-level assertions for the converter and their binding to the top level.
`timescale 1ns / 1ps
module vrl_checker import vrl_pkg::*; (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_ready,
   input logic                   rsp_valid,
   input logic                   rsp_ready,
   input status_type             rsp_status,
   input logic [GAMMA_W-1:0]     rsp_coeff,
   input logic [RL_W-1:0]        rsp_rl,
   input logic [RL_W-1:0]        rsp_ml,
   input logic signed [IL_W-1:0] rsp_il
);
   a_reset_clears: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("Response word valid right after reset.");

   a_error_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_OK |->
         rsp_coeff == '0 && rsp_rl == '0 && rsp_ml == '0 && rsp_il == '0)
      else $error("Error response word carries nonzero values.");

   a_il_sign: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_il > 0))
      else $error("Insertion loss is positive.");

   a_ready_when_empty: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid || rsp_ready |-> req_ready)
      else $error("Request side stalled while the output can move.");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_status) && $stable(rsp_coeff))
      else $error("Stalled response word changed.");
endmodule

bind vswr_to_reflection_and_losses vrl_checker u_vrl_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req.ready),
   .rsp_valid  (rsp.valid),
   .rsp_ready  (rsp.ready),
   .rsp_status (rsp.status),
   .rsp_coeff  (rsp.reflection_coeff),
   .rsp_rl     (rsp.return_loss_db),
   .rsp_ml     (rsp.mismatch_loss_db),
   .rsp_il     (rsp.insertion_loss_db)
);
